### rtl/rvx_pkg.sv
package rvx_pkg;

  localparam logic [31:0] PC_RESET = 32'h0010_0000;
  localparam logic [31:0] SP_RESET = 32'd2048;
  localparam logic [4:0]  SP_INDEX = 5'd2;
  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_JALR = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [31:0] value;
    logic        wr;
    logic        redir;
    logic        ill;
  } exec_res_t;

endpackage

### rtl/rvx_ram.sv
module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/rvx_exec.sv
module rvx_exec
  import rvx_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] pc,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output exec_res_t   res
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  sh;
  logic [31:0] imm_i;
  logic [31:0] imm_j;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] pc_inc;
  logic [31:0] jalr_sum;

  assign opc   = instr[6:0];
  assign f3    = instr[14:12];
  assign f7    = instr[31:25];
  assign sh    = instr[24:20];
  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_u = instr & UPPER_MASK;
  assign pc_inc   = pc + 32'd4;
  assign jalr_sum = a + imm_i;

  always_comb begin
    res.next_pc = pc_inc;
    res.value   = '0;
    res.wr      = 1'b0;
    res.redir   = 1'b0;
    res.ill     = 1'b0;
    case (opc)
      OPC_LUI: begin
        res.value = imm_u;
        res.wr    = 1'b1;
      end
      OPC_AUIPC: begin
        res.value = pc + imm_u;
        res.wr    = 1'b1;
      end
      OPC_JAL: begin
        res.value   = pc_inc;
        res.wr      = 1'b1;
        res.next_pc = pc + imm_j;
        res.redir   = 1'b1;
      end
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          res.value   = pc_inc;
          res.wr      = 1'b1;
          res.next_pc = {jalr_sum[31:1], 1'b0};
          res.redir   = 1'b1;
        end else begin
          res.ill = 1'b1;
        end
      end
      OPC_BRANCH: begin
        if (f3 != F3_BNE) begin
          res.ill = 1'b1;
        end else if (a != b) begin
          res.next_pc = pc + imm_b;
          res.redir   = 1'b1;
        end
      end
      OPC_IMM: begin
        res.wr = 1'b1;
        case (f3)
          F3_ADD:  res.value = jalr_sum;
          F3_SLT:  res.value = {31'd0, $signed(a) < $signed(imm_i)};
          F3_SLTU: res.value = {31'd0, a < imm_i};
          F3_XOR:  res.value = a ^ imm_i;
          F3_OR:   res.value = a | imm_i;
          F3_AND:  res.value = a & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) begin
              res.value = a << sh;
            end else begin
              res.ill = 1'b1;
              res.wr  = 1'b0;
            end
          end
          F3_SR: begin
            if (f7 == F7_BASE) begin
              res.value = a >> sh;
            end else if (f7 == F7_ALT) begin
              res.value = 32'($signed(a) >>> sh);
            end else begin
              res.ill = 1'b1;
              res.wr  = 1'b0;
            end
          end
          default: begin
            res.ill = 1'b1;
            res.wr  = 1'b0;
          end
        endcase
      end
      OPC_REG: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          res.value = a + b;
          res.wr    = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          res.value = a - b;
          res.wr    = 1'b1;
        end else begin
          res.ill = 1'b1;
        end
      end
      default: res.ill = 1'b1;
    endcase
    // illegal encodings only step the pc
    if (res.ill) begin
      res.next_pc = pc_inc;
      res.wr      = 1'b0;
      res.redir   = 1'b0;
      res.value   = '0;
    end
  end

endmodule

### rtl/rv32i_subset_execute_core.sv
// An accepted instruction beat reaches its result beat through the register
// file read, then execute into the result register.
// Throughput: one instruction per cycle while the output is not stalled; a
// result of the previous instruction is forwarded around the register file read.
// Reset: pc = 0x100000, register file reads zero except x2 = 2048, both
// stages empty. No clearing pass; per-register written bits supply reset values.
module rv32i_subset_execute_core
  import rvx_pkg::*;
#(
  parameter int REGISTER_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_fetch_address,
  output logic [4:0]  dest_index,
  output logic [31:0] dest_value,
  output logic        dest_write,
  output logic        redirected,
  output logic        illegal_instr
);

  localparam int AW = $clog2(REGISTER_COUNT);
  localparam logic [5:0] REG_LIMIT = 6'(REGISTER_COUNT);

  logic                      ex_valid;
  logic [31:0]               instr;
  logic [31:0]               pc;
  logic [REGISTER_COUNT-1:0] written;
  logic                      rs1_written;
  logic                      rs2_written;
  logic                      fwd_valid;
  logic [4:0]                fwd_idx;
  logic [31:0]               fwd_val;
  logic [31:0]               ram_a;
  logic [31:0]               ram_b;
  logic [31:0]               op_a;
  logic [31:0]               op_b;
  logic                      accept;
  logic                      ex_fire;
  logic                      out_free;
  logic                      dest_ok;
  logic                      wr_final;
  exec_res_t                 res;

  function automatic logic in_range(input logic [4:0] idx);
    return ({1'b0, idx} < REG_LIMIT) && (idx != 5'd0);
  endfunction

  function automatic logic [31:0] pick(input logic [4:0]  idx,
                                       input logic        was_written,
                                       input logic [31:0] ram_val,
                                       input logic        fv,
                                       input logic [4:0]  fi,
                                       input logic [31:0] fval);
    logic [31:0] r;
    if (!in_range(idx)) begin
      r = '0;
    end else if (fv && fi == idx) begin
      r = fval;
    end else if (was_written) begin
      r = ram_val;
    end else if (idx == SP_INDEX) begin
      r = SP_RESET;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign ex_fire  = ex_valid && out_free;
  assign in_stall = ex_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  assign op_a = pick(instr[19:15], rs1_written, ram_a, fwd_valid, fwd_idx, fwd_val);
  assign op_b = pick(instr[24:20], rs2_written, ram_b, fwd_valid, fwd_idx, fwd_val);

  rvx_exec u_exec (
    .instr (instr),
    .pc    (pc),
    .a     (op_a),
    .b     (op_b),
    .res   (res)
  );

  assign dest_ok  = in_range(instr[11:7]);
  assign wr_final = res.wr && dest_ok;

  rvx_ram #(
    .WIDTH (32),
    .DEPTH (REGISTER_COUNT)
  ) u_regs (
    .clk     (clk),
    .we      (ex_fire && wr_final),
    .waddr   (instr[7+AW-1:7]),
    .wdata   (res.value),
    .re      (accept),
    .raddr_a (instr_word[15+AW-1:15]),
    .raddr_b (instr_word[20+AW-1:20]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= PC_RESET;
      written   <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (ex_fire) begin
        pc <= res.next_pc;
        if (wr_final) begin
          written[instr[7+AW-1:7]] <= 1'b1;
        end
      end
      // catch the write that lands on the same edge as this read
      if (accept) begin
        fwd_valid <= ex_fire && wr_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr       <= instr_word;
      rs1_written <= written[instr_word[15+AW-1:15]];
      rs2_written <= written[instr_word[20+AW-1:20]];
      fwd_idx     <= instr[11:7];
      fwd_val     <= res.value;
    end
    if (ex_fire) begin
      next_fetch_address <= res.next_pc;
      dest_index         <= wr_final ? instr[11:7] : 5'd0;
      dest_value         <= wr_final ? res.value : 32'd0;
      dest_write         <= wr_final;
      redirected         <= res.redir;
      illegal_instr      <= res.ill;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ex_valid && out_valid)
    else $error("input stalled with no item in execute");

  a_pc_holds: assert property (@(posedge clk) disable iff (rst)
    !ex_fire |=> $stable(pc))
    else $error("pc changed without an executed instruction");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    ex_fire |=> out_valid && next_fetch_address == pc)
    else $error("result beat does not match pc after execute");

  a_write_not_x0: assert property (@(posedge clk) disable iff (rst)
    out_valid && dest_write |-> dest_index != 5'd0)
    else $error("write reported to x0");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal_instr |-> !dest_write && !redirected)
    else $error("illegal instruction wrote or redirected");

endmodule

### dv/rv32i_subset_execute_core_tb.sv
module rv32i_subset_execute_core_tb;
  import rvx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_COUNT      = 32;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  rd;
    logic [31:0] value;
    logic        wr;
    logic        redir;
    logic        ill;
  } retire_t;

  typedef struct {
    logic [31:0] word;
    bit          drain;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] instr_word = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] next_fetch_address;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic        dest_write;
  logic        redirected;
  logic        illegal_instr;

  pending_t    pending_instrs[$];
  retire_t     expected_retires[$];
  logic [31:0] arch_regs [REG_COUNT];
  logic [31:0] arch_pc;
  logic        in_taken = 1'b0;
  logic        quiet;
  int          beats_sent = 0;
  int          items_total = 0;
  int          items_accepted = 0;
  int          mismatches = 0;
  int          stuck_cycles = 0;

  rv32i_subset_execute_core #(
    .REGISTER_COUNT(REG_COUNT)
  ) u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .instr_word        (instr_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .next_fetch_address(next_fetch_address),
    .dest_index        (dest_index),
    .dest_value        (dest_value),
    .dest_write        (dest_write),
    .redirected        (redirected),
    .illegal_instr     (illegal_instr)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no random idling on either side over this stretch of beats
  assign quiet = (beats_sent >= 400) && (beats_sent < 700);

  function automatic logic [31:0] read_reg(input logic [4:0] idx);
    if (idx == 5'd0 || int'(idx) >= REG_COUNT) return 32'd0;
    return arch_regs[idx];
  endfunction

  function automatic retire_t execute_instr(input logic [31:0] w);
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm_i;
    logic [31:0] imm_j;
    logic [31:0] imm_b;
    logic [31:0] pc;
    logic [31:0] nxt;
    logic [31:0] val;
    logic        wr;
    logic        redir;
    logic        ill;
    retire_t     r;
    opc   = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    rs1   = w[19:15];
    rs2   = w[24:20];
    f7    = w[31:25];
    pc    = arch_pc;
    nxt   = pc + 32'd4;
    a     = read_reg(rs1);
    b     = read_reg(rs2);
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    val   = 32'd0;
    wr    = 1'b0;
    redir = 1'b0;
    ill   = 1'b0;
    case (opc)
      OPC_LUI: begin
        val = w & UPPER_MASK;
        wr  = 1'b1;
      end
      OPC_AUIPC: begin
        val = pc + (w & UPPER_MASK);
        wr  = 1'b1;
      end
      OPC_JAL: begin
        val   = pc + 32'd4;
        wr    = 1'b1;
        nxt   = pc + imm_j;
        redir = 1'b1;
      end
      OPC_JALR: begin
        if (f3 != F3_JALR) begin
          ill = 1'b1;
        end else begin
          // rs1 was read above, so rd == rs1 sees the old value
          val   = pc + 32'd4;
          wr    = 1'b1;
          nxt   = (a + imm_i) & ~32'd1;
          redir = 1'b1;
        end
      end
      OPC_BRANCH: begin
        if (f3 != F3_BNE) begin
          ill = 1'b1;
        end else if (a != b) begin
          nxt   = pc + imm_b;
          redir = 1'b1;
        end
      end
      OPC_IMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = a + imm_i;
          F3_SLT:  val = {31'd0, $signed(a) < $signed(imm_i)};
          F3_SLTU: val = {31'd0, a < imm_i};
          F3_XOR:  val = a ^ imm_i;
          F3_OR:   val = a | imm_i;
          F3_AND:  val = a & imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << rs2;
            else ill = 1'b1;
          end
          default: begin
            if (f7 == F7_BASE) val = a >> rs2;
            else if (f7 == F7_ALT) val = $signed(a) >>> rs2;
            else ill = 1'b1;
          end
        endcase
      end
      OPC_REG: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          val = a + b;
          wr  = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          val = a - b;
          wr  = 1'b1;
        end else begin
          ill = 1'b1;
        end
      end
      default: ill = 1'b1;
    endcase
    if (ill) begin
      nxt   = pc + 32'd4;
      wr    = 1'b0;
      redir = 1'b0;
    end
    if (rd == 5'd0 || int'(rd) >= REG_COUNT) wr = 1'b0;
    if (wr) begin
      arch_regs[rd] = val;
    end else begin
      val = 32'd0;
      rd  = 5'd0;
    end
    arch_pc   = nxt;
    r.next_pc = nxt;
    r.rd      = rd;
    r.value   = val;
    r.wr      = wr;
    r.redir   = redir;
    r.ill     = ill;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] off, input logic [4:0] rd);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  // favor a few low registers so that back-to-back dependencies are common
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] raw;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    int          pick;
    raw  = $urandom;
    rd   = ($urandom_range(0, 15) == 0) ? 5'd0 : pick_reg();
    rs1  = pick_reg();
    rs2  = pick_reg();
    f3   = raw[14:12];
    pick = $urandom_range(0, 99);
    if (pick < 6) return raw;
    if (pick < 10) return {raw[31:7], 7'($urandom_range(0, 127))};
    if (pick < 18) return enc_u(raw[31:12], rd, OPC_LUI);
    if (pick < 22) return enc_u(raw[31:12], rd, OPC_AUIPC);
    if (pick < 28) return enc_j(raw[20:0], rd);
    if (pick < 34) begin
      if ($urandom_range(0, 7) != 0) f3 = F3_JALR;
      return enc_i(raw[31:20], rs1, f3, rd, OPC_JALR);
    end
    if (pick < 44) begin
      if ($urandom_range(0, 7) != 0) f3 = F3_BNE;
      if ($urandom_range(0, 2) == 0) rs2 = rs1;
      return enc_b(raw[12:0], rs2, rs1, f3);
    end
    if (pick < 76) begin
      if (f3 == F3_SLL || f3 == F3_SR) begin
        f7 = ($urandom_range(0, 1) == 0) ? F7_BASE : F7_ALT;
        if ($urandom_range(0, 9) == 0) f7 = raw[31:25];
        return enc_r(f7, raw[24:20], rs1, f3, rd, OPC_IMM);
      end
      return enc_i(raw[31:20], rs1, f3, rd, OPC_IMM);
    end
    f7 = ($urandom_range(0, 1) == 0) ? F7_BASE : F7_ALT;
    if ($urandom_range(0, 7) != 0) f3 = F3_ADD;
    if ($urandom_range(0, 9) == 0) f7 = raw[31:25];
    return enc_r(f7, rs2, rs1, f3, rd, OPC_REG);
  endfunction

  task automatic add_instr(input logic [31:0] word, input bit drain);
    pending_t item;
    item.word  = word;
    item.drain = drain;
    pending_instrs.push_back(item);
  endtask

  // driver: present beats at the falling edge, hold while stalled
  always @(negedge clk) begin
    pending_t item;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 16);
      if (!in_valid || in_taken) begin
        if (pending_instrs.size() == 0 ||
            (pending_instrs[0].drain && expected_retires.size() != 0) ||
            (!quiet && $urandom_range(0, 99) < 16)) begin
          in_valid <= 1'b0;
        end else begin
          item = pending_instrs.pop_front();
          in_valid   <= 1'b1;
          instr_word <= item.word;
          beats_sent++;
        end
      end
    end
  end

  // monitor: check result beats, predict accepted instruction beats
  always @(posedge clk) begin
    retire_t seen;
    retire_t want;
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = 32'd0;
      arch_regs[SP_INDEX] = SP_RESET;
      arch_pc  = PC_RESET;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        seen.next_pc = next_fetch_address;
        seen.rd      = dest_index;
        seen.value   = dest_value;
        seen.wr      = dest_write;
        seen.redir   = redirected;
        seen.ill     = illegal_instr;
        if (expected_retires.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: pc=%h rd=%0d val=%h wr=%b redir=%b ill=%b",
                     seen.next_pc, seen.rd, seen.value, seen.wr, seen.redir, seen.ill);
        end else begin
          want = expected_retires.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: exp pc=%h rd=%0d val=%h wr=%b redir=%b ill=%b",
                       want.next_pc, want.rd, want.value, want.wr, want.redir, want.ill);
              $display("          got pc=%h rd=%0d val=%h wr=%b redir=%b ill=%b",
                       seen.next_pc, seen.rd, seen.value, seen.wr, seen.redir, seen.ill);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_retires.push_back(execute_instr(instr_word));
        items_accepted++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("rv32i_subset_execute_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    // extremes of immediates, every operation, and the illegal encodings
    add_instr(enc_u(20'hFFFFF, 5'd1, OPC_LUI), 1'b0);
    add_instr(enc_u(20'h80000, 5'd4, OPC_AUIPC), 1'b0);
    add_instr(enc_i(12'h800, 5'd0, F3_ADD, 5'd5, OPC_IMM), 1'b0);
    add_instr(enc_i(12'h7FF, 5'd5, F3_ADD, 5'd6, OPC_IMM), 1'b0);
    add_instr(enc_i(12'h000, 5'd5, F3_SLT, 5'd7, OPC_IMM), 1'b0);
    add_instr(enc_i(12'h001, 5'd5, F3_SLTU, 5'd8, OPC_IMM), 1'b0);
    add_instr(enc_i(12'hFFF, 5'd1, F3_XOR, 5'd9, OPC_IMM), 1'b0);
    add_instr(enc_i(12'h555, 5'd6, F3_OR, 5'd10, OPC_IMM), 1'b0);
    add_instr(enc_i(12'h7F0, 5'd1, F3_AND, 5'd11, OPC_IMM), 1'b0);
    add_instr(enc_r(F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd12, OPC_IMM), 1'b0);
    add_instr(enc_r(F7_BASE, 5'd31, 5'd1, F3_SR, 5'd13, OPC_IMM), 1'b0);
    add_instr(enc_r(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd14, OPC_IMM), 1'b0);
    add_instr(enc_r(F7_ALT, 5'd3, 5'd1, F3_SLL, 5'd15, OPC_IMM), 1'b0);
    add_instr(enc_r(7'h01, 5'd3, 5'd1, F3_SR, 5'd15, OPC_IMM), 1'b0);
    add_instr(enc_r(F7_BASE, 5'd6, 5'd1, F3_ADD, 5'd15, OPC_REG), 1'b0);
    add_instr(enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd16, OPC_REG), 1'b0);
    add_instr(enc_r(F7_BASE, 5'd1, 5'd2, F3_SLL, 5'd17, OPC_REG), 1'b0);
    add_instr(enc_r(7'h01, 5'd1, 5'd2, F3_ADD, 5'd17, OPC_REG), 1'b0);
    add_instr(enc_i(12'h005, 5'd1, F3_ADD, 5'd0, OPC_IMM), 1'b0);
    add_instr(enc_b(13'h1000, 5'd6, 5'd1, F3_BNE), 1'b0);
    add_instr(enc_b(13'h0FFE, 5'd0, 5'd0, F3_BNE), 1'b0);
    add_instr(enc_b(13'h0010, 5'd6, 5'd1, 3'd0), 1'b0);
    add_instr(enc_j(21'h0FFFFE, 5'd1), 1'b0);
    add_instr(enc_j(21'h100000, 5'd0), 1'b0);
    add_instr(enc_i(12'h001, 5'd1, F3_JALR, 5'd1, OPC_JALR), 1'b0);
    add_instr(enc_i(12'h001, 5'd1, 3'd1, 5'd3, OPC_JALR), 1'b0);
    add_instr(32'hFFFF_FFFF, 1'b0);
    add_instr(32'h0000_0000, 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      add_instr(random_instr(), (i == 0) || (i == RANDOM_ITEMS / 2));
    items_total = pending_instrs.size();

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (items_accepted != items_total || expected_retires.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_retires.size() == 0) begin
      $display("rv32i_subset_execute_core regression: pass");
    end else begin
      $display("rv32i_subset_execute_core regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rvx_pkg.sv
rtl/rvx_ram.sv
rtl/rvx_exec.sv
rtl/rv32i_subset_execute_core.sv
dv/rv32i_subset_execute_core_tb.sv
